### hw/rtl/hsp_pkg.sv
package hsp_pkg;

  localparam int CNT_W = 19;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};
  localparam int NSYM = 4;
  localparam int QDEPTH = 2;
  localparam logic [2:0] SORT_LAST = 3'd5;

  typedef enum logic [1:0] {
    CMD_COUNT  = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // queued work item: kind, raw byte and per-symbol occurrence counts
  typedef struct packed {
    cmd_t                  kind;
    logic [7:0]            data;
    logic [NSYM-1:0][2:0]  hist;
  } hsp_item_t;

  typedef struct packed {
    logic [11:0] bits;
    logic [3:0]  len;
  } hsp_code_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SORT,
    B_EMIT
  } back_state_t;

  // concatenate the four rank codes, msb first, left aligned in 12 bits
  function automatic hsp_code_t hsp_encode(input logic [7:0] data, input logic [7:0] ranks);
    hsp_code_t  c;
    logic [1:0] s;
    logic [1:0] r;
    logic [2:0] code;
    logic [1:0] len;
    c.bits = '0;
    c.len  = '0;
    for (int k = 3; k >= 0; k--) begin
      s = data[2*k +: 2];
      r = ranks[2*s +: 2];
      case (r)
        2'd0: begin code = 3'b000; len = 2'd1; end
        2'd1: begin code = 3'b100; len = 2'd2; end
        2'd2: begin code = 3'b110; len = 2'd3; end
        default: begin code = 3'b111; len = 2'd3; end
      endcase
      c.bits = c.bits | ({code, 9'b0} >> c.len);
      c.len  = c.len + 4'(len);
    end
    return c;
  endfunction

endpackage

### hw/rtl/hsp_front.sv
module hsp_front
  import hsp_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic [1:0] s_tuser,
  input  logic       q_full,
  output logic       q_push,
  output hsp_item_t  q_item
);

  cmd_t cmd;

  always_comb begin
    cmd = cmd_t'(s_tuser);
    s_tready = !q_full;
    // the unused command is taken and dropped here
    q_push = s_tvalid && !q_full && (cmd != CMD_NONE);
    q_item.kind = cmd;
    q_item.data = s_tdata;
    q_item.hist = '0;
    for (int k = 0; k < NSYM; k++) begin
      q_item.hist[s_tdata[2*k +: 2]] = q_item.hist[s_tdata[2*k +: 2]] + 3'd1;
    end
  end

endmodule

### hw/rtl/hsp_queue.sv
module hsp_queue
  import hsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hsp_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output hsp_item_t head_item
);

  hsp_item_t mem [QDEPTH];
  logic      wptr;
  logic      rptr;
  logic [1:0] count;

  assign full       = (count == 2'(QDEPTH));
  assign head_valid = (count != 2'd0);
  assign head_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/hsp_back.sv
module hsp_back
  import hsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  hsp_item_t   q_item,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  back_state_t state, state_next;
  logic [CNT_W-1:0] counts [NSYM];
  logic [CNT_W-1:0] counts_next [NSYM];
  logic [7:0]  ranks, ranks_next;
  logic        frozen, frozen_next;
  logic [23:0] acc, acc_next;
  logic [4:0]  acc_len, acc_len_next;
  logic [1:0]  srt_sym [NSYM];
  logic [1:0]  srt_sym_next [NSYM];
  logic [CNT_W-1:0] srt_cnt [NSYM];
  logic [CNT_W-1:0] srt_cnt_next [NSYM];
  logic [2:0]  step, step_next;
  logic        o_valid, o_valid_next;
  logic [7:0]  o_byte, o_byte_next;
  logic [3:0]  o_bits, o_bits_next;
  logic        o_last, o_last_next;
  logic [7:0]  o_ranks, o_ranks_next;
  logic        slot_free;
  hsp_code_t   enc;
  logic [CNT_W:0] sum;
  logic [4:0]  total;

  assign m_tvalid = o_valid;
  assign m_tdata  = {4'b0, o_ranks, o_bits, o_byte};
  assign m_tlast  = o_last;
  assign slot_free = !o_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      ranks   <= '0;
      frozen  <= 1'b0;
      acc     <= '0;
      acc_len <= '0;
      step    <= '0;
      o_valid <= 1'b0;
      for (int s = 0; s < NSYM; s++) counts[s] <= '0;
    end else begin
      state   <= state_next;
      ranks   <= ranks_next;
      frozen  <= frozen_next;
      acc     <= acc_next;
      acc_len <= acc_len_next;
      step    <= step_next;
      o_valid <= o_valid_next;
      for (int s = 0; s < NSYM; s++) counts[s] <= counts_next[s];
    end
  end

  always_ff @(posedge clk) begin
    o_byte  <= o_byte_next;
    o_bits  <= o_bits_next;
    o_last  <= o_last_next;
    o_ranks <= o_ranks_next;
    for (int s = 0; s < NSYM; s++) begin
      srt_sym[s] <= srt_sym_next[s];
      srt_cnt[s] <= srt_cnt_next[s];
    end
  end

  always_comb begin
    state_next   = state;
    ranks_next   = ranks;
    frozen_next  = frozen;
    acc_next     = acc;
    acc_len_next = acc_len;
    step_next    = step;
    o_valid_next = o_valid && !m_tready;
    o_byte_next  = o_byte;
    o_bits_next  = o_bits;
    o_last_next  = o_last;
    o_ranks_next = o_ranks;
    q_pop        = 1'b0;
    sum          = '0;
    enc          = hsp_encode(q_item.data, ranks);
    total        = acc_len + 5'(enc.len);
    for (int s = 0; s < NSYM; s++) begin
      counts_next[s]  = counts[s];
      srt_sym_next[s] = srt_sym[s];
      srt_cnt_next[s] = srt_cnt[s];
    end

    case (state)
      B_IDLE: begin
        if (q_valid) begin
          case (q_item.kind)
            CMD_COUNT: begin
              q_pop = 1'b1;
              if (!frozen) begin
                for (int s = 0; s < NSYM; s++) begin
                  sum = {1'b0, counts[s]} + (CNT_W+1)'(q_item.hist[s]);
                  counts_next[s] = (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[CNT_W-1:0];
                end
              end
            end
            CMD_ENCODE: begin
              if (frozen) begin
                q_pop = 1'b1;
                acc_next     = acc | ({enc.bits, 12'b0} >> acc_len);
                acc_len_next = total;
                if (total >= 5'd8) state_next = B_EMIT;
              end else begin
                // rank the symbols before the first encode item is consumed
                for (int s = 0; s < NSYM; s++) begin
                  srt_sym_next[s] = 2'(s);
                  srt_cnt_next[s] = counts[s];
                end
                step_next  = '0;
                state_next = B_SORT;
              end
            end
            CMD_FLUSH: begin
              if (slot_free) begin
                q_pop        = 1'b1;
                o_valid_next = 1'b1;
                o_byte_next  = acc[23:16];
                o_bits_next  = acc_len[3:0];
                o_last_next  = 1'b1;
                o_ranks_next = ranks;
                ranks_next   = '0;
                frozen_next  = 1'b0;
                acc_next     = '0;
                acc_len_next = '0;
                for (int s = 0; s < NSYM; s++) counts_next[s] = '0;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end

      B_SORT: begin
        // one compare and swap per cycle, fixed pair order of the swap sort
        case (step)
          3'd0: if (srt_cnt[3] > srt_cnt[0]) begin
            srt_cnt_next[0] = srt_cnt[3]; srt_cnt_next[3] = srt_cnt[0];
            srt_sym_next[0] = srt_sym[3]; srt_sym_next[3] = srt_sym[0];
          end
          3'd1: if (srt_cnt[2] > srt_cnt[0]) begin
            srt_cnt_next[0] = srt_cnt[2]; srt_cnt_next[2] = srt_cnt[0];
            srt_sym_next[0] = srt_sym[2]; srt_sym_next[2] = srt_sym[0];
          end
          3'd2: if (srt_cnt[1] > srt_cnt[0]) begin
            srt_cnt_next[0] = srt_cnt[1]; srt_cnt_next[1] = srt_cnt[0];
            srt_sym_next[0] = srt_sym[1]; srt_sym_next[1] = srt_sym[0];
          end
          3'd3: if (srt_cnt[3] > srt_cnt[1]) begin
            srt_cnt_next[1] = srt_cnt[3]; srt_cnt_next[3] = srt_cnt[1];
            srt_sym_next[1] = srt_sym[3]; srt_sym_next[3] = srt_sym[1];
          end
          3'd4: if (srt_cnt[2] > srt_cnt[1]) begin
            srt_cnt_next[1] = srt_cnt[2]; srt_cnt_next[2] = srt_cnt[1];
            srt_sym_next[1] = srt_sym[2]; srt_sym_next[2] = srt_sym[1];
          end
          3'd5: if (srt_cnt[3] > srt_cnt[2]) begin
            srt_cnt_next[2] = srt_cnt[3]; srt_cnt_next[3] = srt_cnt[2];
            srt_sym_next[2] = srt_sym[3]; srt_sym_next[3] = srt_sym[2];
          end
          default: ;
        endcase
        step_next = step + 3'd1;
        if (step == SORT_LAST) begin
          for (int s = 0; s < NSYM; s++) begin
            for (int p = 0; p < NSYM; p++) begin
              if (srt_sym_next[p] == 2'(s)) ranks_next[2*s +: 2] = 2'(p);
            end
          end
          frozen_next = 1'b1;
          state_next  = B_IDLE;
        end
      end

      B_EMIT: begin
        if (slot_free) begin
          o_valid_next = 1'b1;
          o_byte_next  = acc[23:16];
          o_bits_next  = 4'd8;
          o_last_next  = 1'b0;
          o_ranks_next = ranks;
          acc_next     = {acc[15:0], 8'h00};
          acc_len_next = acc_len - 5'd8;
          if (acc_len < 5'd16) state_next = B_IDLE;
        end
      end

      default: state_next = B_IDLE;
    endcase
  end

endmodule

### hw/rtl/two_bit_symbol_huffman_packer.sv
// static huffman packer for bytes of four 2-bit symbols, bits 7:6 first
// input stream: s_tuser carries the command (count, encode, flush), s_tdata
// the byte; a count pass tallies symbols, the first encode ranks them and
// freezes the code table, encode bytes are packed with codes 0/10/110/111
// output stream: one transfer per full packed byte, plus one with m_tlast
// high for a flush carrying the partial byte and its valid-bit count
// a front stage classifies items into a two-entry queue; the back stage
// executes them and drives a registered output
// the back stage executes one queued item at a time; an encode that completes
// output bytes emits them before the next item; the first encode starts the ranking
// and then does six compare and swap steps, one per cycle, in the back stage
// with an empty queue and a free output, a flush result passes the queue and then
// the registered output, the first byte of an encode the queue, the bit accumulator and the output
// reset clears counts, table, pending bits, queue and output valid
// when m_tready is low the output holds, the back stage waits at a flush or an
// output byte, and input keeps being taken until the queue fills
module two_bit_symbol_huffman_packer
  import hsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte[7:0], out_bits[11:8], code_ranks[19:12]
  output logic        m_tlast
);

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  hsp_item_t push_item;
  hsp_item_t head_item;

  hsp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  hsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  hsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (head_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### bench/two_bit_symbol_huffman_packer_tb.sv
`timescale 1ns / 1ps

module two_bit_symbol_huffman_packer_tb;
  import hsp_pkg::*;

  // one output transfer as the packer should produce it
  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] out_bits;
    logic       out_last;
    logic [7:0] code_ranks;
  } packed_byte_t;

  localparam int RANDOM_ITEMS = 1560;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // data_byte
  logic [1:0]  s_tuser = '0;   // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // out_byte[7:0], out_bits[11:8], code_ranks[19:12]
  logic        m_tlast;

  // packer model state
  logic [CNT_W-1:0] sym_count [NSYM];
  logic [1:0]       sym_rank [NSYM];
  logic             table_frozen;
  logic [7:0]       partial_byte;
  int               fill_bits;
  packed_byte_t     expected_bytes [$];

  int error_count = 0;
  int items_sent = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  int stall_left = 0;

  always #1 clk = ~clk;

  two_bit_symbol_huffman_packer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // mostly short gaps, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] packed_ranks();
    return {sym_rank[3], sym_rank[2], sym_rank[1], sym_rank[0]};
  endfunction

  task automatic clear_packer_model();
    for (int i = 0; i < NSYM; i++) begin
      sym_count[i] = '0;
      sym_rank[i]  = '0;
    end
    table_frozen = 1'b0;
    partial_byte = '0;
    fill_bits    = 0;
  endtask

  // swap sort on counts, strictly greater swaps, starting in symbol order
  task automatic rank_symbols();
    int               order [NSYM];
    logic [CNT_W-1:0] cnt [NSYM];
    int               t;
    logic [CNT_W-1:0] tc;
    for (int i = 0; i < NSYM; i++) begin
      order[i] = i;
      cnt[i]   = sym_count[i];
    end
    for (int i = 0; i < NSYM - 1; i++) begin
      for (int j = NSYM - 1; j > i; j--) begin
        if (cnt[j] > cnt[i]) begin
          t = order[j]; order[j] = order[i]; order[i] = t;
          tc = cnt[j]; cnt[j] = cnt[i]; cnt[i] = tc;
        end
      end
    end
    for (int i = 0; i < NSYM; i++) sym_rank[order[i]] = 2'(i);
    table_frozen = 1'b1;
  endtask

  task automatic push_code_bit(input logic b);
    if (b) partial_byte[7 - fill_bits] = 1'b1;
    fill_bits++;
    if (fill_bits == 8) begin
      expected_bytes.push_back('{partial_byte, 4'd8, 1'b0, packed_ranks()});
      partial_byte = '0;
      fill_bits    = 0;
    end
  endtask

  task automatic predict_transfer(input cmd_t cmd, input logic [7:0] data);
    logic [1:0] s;
    logic [1:0] r;
    case (cmd)
      CMD_COUNT: begin
        if (!table_frozen) begin
          for (int k = 3; k >= 0; k--) begin
            s = data[2*k +: 2];
            if (sym_count[s] != COUNT_LIMIT) sym_count[s] = sym_count[s] + 1'b1;
          end
        end
      end
      CMD_ENCODE: begin
        if (!table_frozen) rank_symbols();
        // rank r codes as r ones followed by a zero, except the last rank
        for (int k = 3; k >= 0; k--) begin
          s = data[2*k +: 2];
          r = sym_rank[s];
          for (int b = 0; b < r; b++) push_code_bit(1'b1);
          if (r != 2'd3) push_code_bit(1'b0);
        end
      end
      CMD_FLUSH: begin
        expected_bytes.push_back('{partial_byte, 4'(fill_bits), 1'b1, packed_ranks()});
        clear_packer_model();
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input cmd_t cmd, input logic [7:0] data);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_transfer(cmd, data);
    items_sent++;
    gap = tx_gaps ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every predicted byte has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected transfer: byte %02h bits %0d last %0b ranks %02h",
                   m_tdata[7:0], m_tdata[11:8], m_tlast, m_tdata[19:12]);
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== {4'b0, want.code_ranks, want.out_bits, want.out_byte}
            || m_tlast !== want.out_last) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch: expected byte %02h bits %0d last %0b ranks %02h, ",
                      "%s %02h %0d %0b %02h pad %h"},
                     want.out_byte, want.out_bits, want.out_last, want.code_ranks,
                     "got", m_tdata[7:0], m_tdata[11:8], m_tlast, m_tdata[19:12],
                     m_tdata[23:20]);
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!rx_stalls || $urandom_range(0, 99) < 65) begin
      m_tready <= 1'b1;
    end else begin
      stall_left = idle_length();
      m_tready <= 1'b0;
    end
  end

  task automatic test_unused_and_empty_flush();
    send_item(CMD_FLUSH, 8'h00);
    send_item(CMD_NONE, 8'hFF);
    send_item(CMD_FLUSH, 8'hFF);
    wait_drained();
  endtask

  // zero counts leave rank equal to symbol value
  task automatic test_encode_without_counts();
    send_item(CMD_ENCODE, 8'h00);
    send_item(CMD_ENCODE, 8'hFF);
    send_item(CMD_ENCODE, 8'h1B);
    send_item(CMD_ENCODE, 8'hE4);
    send_item(CMD_ENCODE, 8'hAA);
    send_item(CMD_ENCODE, 8'h55);
    send_item(CMD_FLUSH, 8'h00);
    wait_drained();
  endtask

  task automatic test_count_after_freeze();
    send_item(CMD_COUNT, 8'hFF);
    send_item(CMD_COUNT, 8'hFF);
    send_item(CMD_COUNT, 8'hAA);
    send_item(CMD_COUNT, 8'h00);
    send_item(CMD_COUNT, 8'h5A);
    send_item(CMD_ENCODE, 8'hE4);
    send_item(CMD_COUNT, 8'h00);
    send_item(CMD_COUNT, 8'h00);
    send_item(CMD_NONE, 8'h00);
    send_item(CMD_ENCODE, 8'h1B);
    send_item(CMD_ENCODE, 8'hFF);
    send_item(CMD_FLUSH, 8'hFF);
    wait_drained();
  endtask

  // symbols drawn with a bias toward a random favorite order
  function automatic logic [7:0] skewed_byte(input logic [7:0] fav);
    logic [7:0] b;
    int         r;
    int         p;
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(0, 15);
      p = (r < 8) ? 0 : (r < 12) ? 1 : (r < 14) ? 2 : 3;
      b[2*k +: 2] = fav[2*p +: 2];
    end
    return b;
  endfunction

  task automatic test_random_jobs();
    int         first_item;
    int         job;
    int         n_count;
    int         n_encode;
    int         j;
    logic [7:0] fav;
    logic [1:0] t;
    first_item = items_sent;
    job = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (job % 5 == 0) begin
        tx_gaps   = $urandom_range(0, 3) != 0;
        rx_stalls = $urandom_range(0, 3) != 0;
      end
      fav = 8'b11_10_01_00;
      for (int i = 3; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = fav[2*i +: 2];
        fav[2*i +: 2] = fav[2*j +: 2];
        fav[2*j +: 2] = t;
      end
      n_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      for (int i = 0; i < n_count; i++)
        send_item(CMD_COUNT, ($urandom_range(0, 3) == 0) ? 8'($urandom) : skewed_byte(fav));
      n_encode = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
      for (int i = 0; i < n_encode; i++) begin
        case ($urandom_range(0, 19))
          0: send_item(CMD_NONE, 8'($urandom));
          1: send_item(CMD_COUNT, 8'($urandom));
          default: send_item(CMD_ENCODE,
                             ($urandom_range(0, 1) == 0) ? 8'($urandom) : skewed_byte(fav));
        endcase
      end
      // now and then a job runs on without its flush
      if ($urandom_range(0, 99) < 85) send_item(CMD_FLUSH, 8'($urandom));
      if (job % 7 == 3) wait_drained();
      job++;
    end
    send_item(CMD_FLUSH, 8'h00);
    wait_drained();
  endtask

  initial begin
    clear_packer_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unused_and_empty_flush();
    test_encode_without_counts();
    rx_stalls = 1'b1;
    test_count_after_freeze();
    test_random_jobs();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
